>>> design/dltq_pkg.sv
// Shared types and codes for the delta-list timer queue.
// Used by the controller, the datapath and the top level; depends on nothing.
`default_nettype none
package dltq_pkg;

    typedef struct packed {
        logic [2:0]  kind;
        logic [7:0]  elapsed;
        logic [15:0] time_value;
        logic [7:0]  callback_id;
        logic [15:0] arg_id;
    } req_word_t;

    typedef struct packed {
        logic        is_fire;
        logic [7:0]  fired_callback;
        logic [15:0] fired_arg;
        logic [2:0]  status;
        logic [4:0]  removed_count;
        logic        last;
    } res_word_t;

    typedef logic [2:0] kind_t;
    localparam kind_t KIND_TICK      = 3'd0;
    localparam kind_t KIND_ADD_ONCE  = 3'd1;
    localparam kind_t KIND_ADD_PER   = 3'd2;
    localparam kind_t KIND_RM_EXACT  = 3'd3;
    localparam kind_t KIND_RM_ONCE   = 3'd4;
    localparam kind_t KIND_RM_ARG    = 3'd5;

    typedef logic [2:0] status_t;
    localparam status_t ST_OK        = 3'd0;
    localparam status_t ST_ZERO_TIME = 3'd1;
    localparam status_t ST_FULL      = 3'd2;
    localparam status_t ST_NOT_FOUND = 3'd3;
    localparam status_t ST_CAPPED    = 3'd4;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DISPATCH,
        S_TICK,
        S_TICK_END,
        S_INS_SCAN,
        S_RM_SCAN,
        S_RM_DONE,
        S_RALL_SCAN
    } ctrl_state_t;

    typedef struct packed {
        logic    load;
        logic    head_spend;
        logic    head_fire;
        logic    ins_step;
        logic    ins_write;
        logic    idx_inc;
        logic    rm_at;
        logic    tick_end;
        logic    emit_status;
        logic    emit_count;
        status_t status_code;
    } dp_cmd_t;

    typedef struct packed {
        kind_t kind;
        logic  tval_zero;
        logic  full;
        logic  empty;
        logic  cap;
        logic  head_gt;
        logic  head_periodic;
        logic  idx_end;
        logic  scan_stop;
        logic  match;
        logic  removed_any;
    } dp_stat_t;

endpackage
`default_nettype wire

>>> design/delta_list_timer_queue.sv
// Delta-list timer queue: top level joining the controller and the datapath.
// Depends on dltq_pkg, dltq_ctrl and dltq_dpath.
//
// Usage: a request word (kind, elapsed, time_value, callback_id, arg_id) is
// taken on a rising edge where start is high and busy is low. Busy rises on
// the next cycle and stays high until the request's last result word has
// been issued. Each result word is shown on result for exactly one cycle
// with result_strobe high; the receiver cannot hold it off and must take it.
// The final result word of a request carries last = 1.
//
// Latency depends on the request kind and on the number of queued timers N
// (at most SLOTS). An add runs an insertion scan over the queued timers.
// A remove scans one slot per cycle.
// A tick fires the due timers one after another, and a periodic timer that
// fires is put back by a further insertion scan; at most MAX_FIRES timers
// fire per tick. A single scan index over the slot table serves all of these
// scans. Fire words of a tick come out one per firing, the last one when the
// tick finishes.
//
// Reset clears the queue, the time backlog and the controller at once; the
// slot payload is left unset and is never read before it is written.
`default_nettype none
module delta_list_timer_queue
    import dltq_pkg::*;
#(
    parameter int SLOTS     = 16,
    parameter int TIME_BITS = 16,
    parameter int MAX_FIRES = 64
)
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      start,
    output logic           busy,
    input  wire req_word_t request,
    output res_word_t      result,
    output logic           result_strobe
);

    dp_cmd_t  cmd;
    dp_stat_t stat;

    // The controller walks each request through its scan and update steps.
    dltq_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .stat  (stat),
        .cmd   (cmd)
    );

    // The datapath owns the slot table and builds every result word.
    dltq_dpath #(
        .SLOTS     (SLOTS),
        .TIME_BITS (TIME_BITS),
        .MAX_FIRES (MAX_FIRES)
    ) u_dpath (
        .clk           (clk),
        .rst_n         (rst_n),
        .request       (request),
        .cmd           (cmd),
        .stat          (stat),
        .result        (result),
        .result_strobe (result_strobe)
    );

endmodule
`default_nettype wire

>>> design/dltq_ctrl.sv
// Sequencing state machine of the delta-list timer queue.
// Depends on dltq_pkg; drives the datapath by dp_cmd_t and reads dp_stat_t.
`default_nettype none
module dltq_ctrl
    import dltq_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     start,
    output logic          busy,
    input  wire dp_stat_t stat,
    output dp_cmd_t       cmd
);

    ctrl_state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        busy       = (state_reg != S_IDLE);
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                priority if (stat.kind == KIND_TICK)
                begin
                    state_next = S_TICK;
                end
                else if (stat.kind == KIND_ADD_ONCE || stat.kind == KIND_ADD_PER)
                begin
                    priority if (stat.tval_zero)
                    begin
                        cmd.emit_status = 1'b1;
                        cmd.status_code = ST_ZERO_TIME;
                        state_next      = S_IDLE;
                    end
                    else if (stat.full)
                    begin
                        cmd.emit_status = 1'b1;
                        cmd.status_code = ST_FULL;
                        state_next      = S_IDLE;
                    end
                    else
                    begin
                        state_next = S_INS_SCAN;
                    end
                end
                else if (stat.kind == KIND_RM_EXACT || stat.kind == KIND_RM_ONCE)
                begin
                    state_next = S_RM_SCAN;
                end
                else if (stat.kind == KIND_RM_ARG)
                begin
                    state_next = S_RALL_SCAN;
                end
                else
                begin
                    cmd.emit_status = 1'b1;
                    cmd.status_code = ST_OK;
                    state_next      = S_IDLE;
                end
            end
            S_TICK:
            begin
                priority if (stat.empty || stat.cap)
                begin
                    state_next = S_TICK_END;
                end
                else if (stat.head_gt)
                begin
                    cmd.head_spend = 1'b1;
                    state_next     = S_TICK_END;
                end
                else
                begin
                    cmd.head_fire = 1'b1;
                    if (stat.head_periodic)
                    begin
                        state_next = S_INS_SCAN;
                    end
                end
            end
            S_TICK_END:
            begin
                cmd.tick_end = 1'b1;
                state_next   = S_IDLE;
            end
            S_INS_SCAN:
            begin
                if (stat.idx_end || stat.scan_stop)
                begin
                    cmd.ins_write = 1'b1;
                    if (stat.kind == KIND_TICK)
                    begin
                        state_next = S_TICK;
                    end
                    else
                    begin
                        cmd.emit_status = 1'b1;
                        cmd.status_code = ST_OK;
                        state_next      = S_IDLE;
                    end
                end
                else
                begin
                    cmd.ins_step = 1'b1;
                end
            end
            S_RM_SCAN:
            begin
                priority if (stat.idx_end)
                begin
                    cmd.emit_status = 1'b1;
                    cmd.status_code = ST_NOT_FOUND;
                    state_next      = S_IDLE;
                end
                else if (stat.match)
                begin
                    cmd.rm_at  = 1'b1;
                    state_next = S_RM_DONE;
                end
                else
                begin
                    cmd.idx_inc = 1'b1;
                end
            end
            S_RM_DONE:
            begin
                cmd.emit_status = 1'b1;
                cmd.emit_count  = 1'b1;
                cmd.status_code = ST_OK;
                state_next      = S_IDLE;
            end
            S_RALL_SCAN:
            begin
                priority if (stat.idx_end)
                begin
                    cmd.emit_status = 1'b1;
                    cmd.emit_count  = 1'b1;
                    cmd.status_code = stat.removed_any ? ST_OK : ST_NOT_FOUND;
                    state_next      = S_IDLE;
                end
                else if (stat.match)
                begin
                    cmd.rm_at = 1'b1;
                end
                else
                begin
                    cmd.idx_inc = 1'b1;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

>>> design/dltq_dpath.sv
// Datapath of the delta-list timer queue: slot table, scan index, time and
// result registers. Depends on dltq_pkg; commanded by dltq_ctrl.
`default_nettype none
module dltq_dpath
    import dltq_pkg::*;
#(
    parameter int SLOTS     = 16,
    parameter int TIME_BITS = 16,
    parameter int MAX_FIRES = 64
)
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire req_word_t request,
    input  wire dp_cmd_t   cmd,
    output dp_stat_t       stat,
    output res_word_t      result,
    output logic           result_strobe
);

    localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CW = $clog2(SLOTS + 1);
    localparam int KW = $clog2(MAX_FIRES + 1);
    localparam int XW = (TIME_BITS > 16) ? TIME_BITS : 16;
    localparam logic [XW-1:0] TMAX_X = XW'({TIME_BITS{1'b1}});

    typedef logic [TIME_BITS-1:0] tm_t;

    // Slot table payload.
    logic [7:0]  cb_reg    [SLOTS];
    logic [15:0] arg_reg   [SLOTS];
    tm_t         per_reg   [SLOTS];
    tm_t         delta_reg [SLOTS];
    logic [7:0]  cb_next    [SLOTS];
    logic [15:0] arg_next   [SLOTS];
    tm_t         per_next   [SLOTS];
    tm_t         delta_next [SLOTS];

    // Control and working registers.
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [CW-1:0] idx_reg, idx_next;
    logic [KW-1:0] k_reg, k_next;
    logic [CW-1:0] removed_reg, removed_next;
    tm_t           backlog_reg, backlog_next;
    tm_t           todo_reg, todo_next;
    tm_t           rem_reg, rem_next;
    logic          pend_valid_reg, pend_valid_next;
    logic          strobe_reg, strobe_next;
    kind_t         kind_reg, kind_next;
    logic [7:0]    ins_cb_reg, ins_cb_next;
    logic [15:0]   ins_arg_reg, ins_arg_next;
    tm_t           ins_per_reg, ins_per_next;
    tm_t           want_per_reg, want_per_next;
    logic [7:0]    pend_cb_reg, pend_cb_next;
    logic [15:0]   pend_arg_reg, pend_arg_next;
    res_word_t     res_reg, res_next;

    logic [IW-1:0]    idx_w;
    logic [IW-1:0]    rm_i;
    tm_t              tval_sat;
    logic [XW-1:0]    tval_x;
    logic [TIME_BITS:0] todo_sum;
    tm_t              todo_init;
    tm_t              delta_at;
    tm_t              rm_add;
    logic             head_gt;
    logic             empty;
    logic [4:0]       removed_sat;

    assign idx_w    = idx_reg[IW-1:0];
    assign tval_x   = XW'(request.time_value);
    assign tval_sat = (tval_x > TMAX_X) ? TIME_BITS'(TMAX_X) : TIME_BITS'(tval_x);
    assign todo_sum = {1'b0, backlog_reg} + (TIME_BITS + 1)'(request.elapsed);
    assign todo_init = todo_sum[TIME_BITS] ? {TIME_BITS{1'b1}} : todo_sum[TIME_BITS-1:0];
    assign delta_at = delta_reg[idx_w];
    assign head_gt  = delta_reg[0] > todo_reg;
    assign empty    = (cnt_reg == '0);
    assign rm_i     = cmd.head_fire ? '0 : idx_w;
    assign rm_add   = cmd.head_fire ? '0 : delta_at;
    assign removed_sat = (removed_reg > CW'(31)) ? 5'd31 : 5'(removed_reg);

    always_comb
    begin
        stat.kind          = kind_reg;
        stat.tval_zero     = (rem_reg == '0);
        stat.full          = (cnt_reg == CW'(SLOTS));
        stat.empty         = empty;
        stat.cap           = (k_reg == KW'(MAX_FIRES));
        stat.head_gt       = head_gt;
        stat.head_periodic = (per_reg[0] != '0);
        stat.idx_end       = (idx_reg == cnt_reg);
        stat.scan_stop     = (delta_at > rem_reg);
        if (kind_reg == KIND_RM_ARG)
        begin
            stat.match = (arg_reg[idx_w] == ins_arg_reg);
        end
        else
        begin
            stat.match = (cb_reg[idx_w] == ins_cb_reg) && (arg_reg[idx_w] == ins_arg_reg)
                         && (per_reg[idx_w] == want_per_reg);
        end
        stat.removed_any = (removed_reg != '0);
    end

    always_comb
    begin
        cb_next         = cb_reg;
        arg_next        = arg_reg;
        per_next        = per_reg;
        delta_next      = delta_reg;
        cnt_next        = cnt_reg;
        idx_next        = idx_reg;
        k_next          = k_reg;
        removed_next    = removed_reg;
        backlog_next    = backlog_reg;
        todo_next       = todo_reg;
        rem_next        = rem_reg;
        pend_valid_next = pend_valid_reg;
        kind_next       = kind_reg;
        ins_cb_next     = ins_cb_reg;
        ins_arg_next    = ins_arg_reg;
        ins_per_next    = ins_per_reg;
        want_per_next   = want_per_reg;
        pend_cb_next    = pend_cb_reg;
        pend_arg_next   = pend_arg_reg;
        res_next        = res_reg;
        strobe_next     = 1'b0;

        if (cmd.load)
        begin
            kind_next       = request.kind;
            todo_next       = todo_init;
            rem_next        = tval_sat;
            ins_cb_next     = request.callback_id;
            ins_arg_next    = request.arg_id;
            ins_per_next    = (request.kind == KIND_ADD_PER) ? tval_sat : '0;
            want_per_next   = (request.kind == KIND_RM_EXACT) ? tval_sat : '0;
            idx_next        = '0;
            k_next          = '0;
            removed_next    = '0;
            pend_valid_next = 1'b0;
        end

        if (cmd.head_spend)
        begin
            delta_next[0] = delta_reg[0] - todo_reg;
            todo_next     = '0;
        end

        // Pop an entry: the head on a fire, the scanned entry on a remove.
        if (cmd.head_fire || cmd.rm_at)
        begin
            for (int j = 0; j < SLOTS - 1; j++)
            begin
                if (IW'(j) >= rm_i)
                begin
                    cb_next[j]    = cb_reg[j+1];
                    arg_next[j]   = arg_reg[j+1];
                    per_next[j]   = per_reg[j+1];
                    delta_next[j] = (IW'(j) == rm_i) ? delta_reg[j+1] + rm_add
                                                      : delta_reg[j+1];
                end
            end
            cnt_next = cnt_reg - CW'(1);
        end

        if (cmd.head_fire)
        begin
            todo_next    = todo_reg - delta_reg[0];
            ins_cb_next  = cb_reg[0];
            ins_arg_next = arg_reg[0];
            ins_per_next = per_reg[0];
            rem_next     = per_reg[0];
            idx_next     = '0;
            k_next       = k_reg + KW'(1);
            if (pend_valid_reg)
            begin
                res_next    = '{1'b1, pend_cb_reg, pend_arg_reg, ST_OK, 5'd0, 1'b0};
                strobe_next = 1'b1;
            end
            pend_valid_next = 1'b1;
            pend_cb_next    = cb_reg[0];
            pend_arg_next   = arg_reg[0];
        end

        if (cmd.rm_at)
        begin
            removed_next = removed_reg + CW'(1);
        end

        if (cmd.idx_inc)
        begin
            idx_next = idx_reg + CW'(1);
        end

        if (cmd.ins_step)
        begin
            rem_next = rem_reg - delta_at;
            idx_next = idx_reg + CW'(1);
        end

        if (cmd.ins_write)
        begin
            // Entries behind the insertion point move back by one.
            for (int j = 1; j < SLOTS; j++)
            begin
                if (CW'(j) > idx_reg)
                begin
                    cb_next[j]    = cb_reg[j-1];
                    arg_next[j]   = arg_reg[j-1];
                    per_next[j]   = per_reg[j-1];
                    delta_next[j] = (CW'(j) == idx_reg + CW'(1)) ? delta_reg[j-1] - rem_reg
                                                                  : delta_reg[j-1];
                end
            end
            for (int j = 0; j < SLOTS; j++)
            begin
                if (CW'(j) == idx_reg)
                begin
                    cb_next[j]    = ins_cb_reg;
                    arg_next[j]   = ins_arg_reg;
                    per_next[j]   = ins_per_reg;
                    delta_next[j] = rem_reg;
                end
            end
            cnt_next = cnt_reg + CW'(1);
        end

        if (cmd.tick_end)
        begin
            if (!empty && head_gt)
            begin
                delta_next[0] = delta_reg[0] - todo_reg;
            end
            backlog_next = (empty || head_gt) ? '0 : todo_reg;
            if (k_reg == '0)
            begin
                res_next = '{1'b0, 8'd0, 16'd0, ST_OK, 5'd0, 1'b1};
            end
            else
            begin
                res_next = '{1'b1, pend_cb_reg, pend_arg_reg,
                             (empty || head_gt || todo_reg == '0) ? ST_OK : ST_CAPPED,
                             5'd0, 1'b1};
            end
            strobe_next     = 1'b1;
            pend_valid_next = 1'b0;
        end

        if (cmd.emit_status)
        begin
            res_next    = '{1'b0, 8'd0, 16'd0, cmd.status_code,
                            cmd.emit_count ? removed_sat : 5'd0, 1'b1};
            strobe_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg        <= '0;
            idx_reg        <= '0;
            k_reg          <= '0;
            removed_reg    <= '0;
            backlog_reg    <= '0;
            pend_valid_reg <= 1'b0;
            strobe_reg     <= 1'b0;
            kind_reg       <= KIND_TICK;
        end
        else
        begin
            cnt_reg        <= cnt_next;
            idx_reg        <= idx_next;
            k_reg          <= k_next;
            removed_reg    <= removed_next;
            backlog_reg    <= backlog_next;
            pend_valid_reg <= pend_valid_next;
            strobe_reg     <= strobe_next;
            kind_reg       <= kind_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cb_reg       <= cb_next;
        arg_reg      <= arg_next;
        per_reg      <= per_next;
        delta_reg    <= delta_next;
        todo_reg     <= todo_next;
        rem_reg      <= rem_next;
        ins_cb_reg   <= ins_cb_next;
        ins_arg_reg  <= ins_arg_next;
        ins_per_reg  <= ins_per_next;
        want_per_reg <= want_per_next;
        pend_cb_reg  <= pend_cb_next;
        pend_arg_reg <= pend_arg_next;
        res_reg      <= res_next;
    end

    assign result        = res_reg;
    assign result_strobe = strobe_reg;

endmodule
`default_nettype wire
